// ===== design/kps_pkg.sv =====
// kps_pkg: shared types, constants and the key code table of the keypad
// to pulse width serial block; used by every file in design/
// depends on nothing
package kps_pkg;

   localparam int KEY_LINES_DEF = 4;
   localparam int CHAR_BITS_DEF = 8;

   localparam int MASK_W      = 16;
   localparam int TICK_W      = 16;
   localparam int CODE_W      = 8;
   localparam int COUNT_W     = 10;
   localparam int CSR_INDEX_W = 4;

   localparam logic [COUNT_W-1:0] PRESS_LAST = COUNT_W'(999);

   localparam logic [TICK_W-1:0] ONE_HALF_RESET  = TICK_W'(500);
   localparam logic [TICK_W-1:0] ZERO_HALF_RESET = TICK_W'(1000);

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HALF  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HALF = CSR_INDEX_W'(1);

   // item kinds
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // 4x4 keypad legend, row-major
   localparam logic [CODE_W-1:0] KEY_CODES [16] = '{
      8'h31, 8'h32, 8'h33, 8'h41,
      8'h34, 8'h35, 8'h36, 8'h42,
      8'h37, 8'h38, 8'h39, 8'h43,
      8'h2A, 8'h30, 8'h23, 8'h44
   };

   typedef struct packed {
      logic              cmd;
      logic [MASK_W-1:0] key_mask;
   } req_type;

   typedef struct packed {
      logic               line_level;
      logic               busy_res;
      logic               sample_taken;
      logic               new_press;
      logic [CODE_W-1:0]  key_code;
      logic [COUNT_W-1:0] press_count;
      logic               char_done;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] one_half_ticks;
      logic [TICK_W-1:0] zero_half_ticks;
   } cfg_type;

   // keys outside the 4x4 legend give code 0
   function automatic logic [CODE_W-1:0] key_ascii(input logic [2:0] row,
                                                   input logic [2:0] col);
      logic [CODE_W-1:0] code;
      code = '0;
      if (!row[2] && !col[2]) begin
         code = KEY_CODES[{row[1:0], col[1:0]}];
      end
      return code;
   endfunction

endpackage

// ===== design/kps_csr.sv =====
// kps_csr: the two phase length registers behind the csr write port
// depends on kps_pkg
module kps_csr
   import kps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]      csr_wdata,
   output cfg_type                cfg
);

   logic [TICK_W-1:0] one_half_ff;
   logic [TICK_W-1:0] zero_half_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_half_ff  <= ONE_HALF_RESET;
         zero_half_ff <= ZERO_HALF_RESET;
      end else if (csr_valid) begin
         // unknown indexes are dropped
         if (csr_index == CSR_ONE_HALF) begin
            one_half_ff <= csr_wdata;
         end
         if (csr_index == CSR_ZERO_HALF) begin
            zero_half_ff <= csr_wdata;
         end
      end
   end

   assign cfg.one_half_ticks  = one_half_ff;
   assign cfg.zero_half_ticks = zero_half_ff;

endmodule

// ===== design/kps_key_decode.sv =====
// kps_key_decode: priority encoder over the keypad grid, lowest pressed row
// and lowest pressed column, then the legend lookup; depends on kps_pkg
module kps_key_decode
   import kps_pkg::*;
#(
   parameter int KEY_LINES = KEY_LINES_DEF
)
(
   input  logic [MASK_W-1:0] key_mask,
   output logic              found,
   output logic [CODE_W-1:0] code
);

   localparam int GRID   = KEY_LINES * KEY_LINES;
   localparam int LINE_W = (KEY_LINES > 1) ? $clog2(KEY_LINES) : 1;

   logic [GRID+MASK_W-1:0] mask_ext;
   logic [GRID-1:0]        grid;
   logic [KEY_LINES-1:0]   row_any;
   logic [KEY_LINES-1:0]   col_any;
   logic [LINE_W-1:0]      row;
   logic [LINE_W-1:0]      col;

   // grid positions past the 16 mask bits read as released
   assign mask_ext = {{GRID{1'b0}}, key_mask};
   assign grid     = mask_ext[GRID-1:0];

   always_comb begin
      row_any = '0;
      col_any = '0;
      for (int r = 0; r < KEY_LINES; r++) begin
         for (int c = 0; c < KEY_LINES; c++) begin
            row_any[r] = row_any[r] | grid[r*KEY_LINES + c];
            col_any[c] = col_any[c] | grid[r*KEY_LINES + c];
         end
      end
      row = '0;
      col = '0;
      for (int i = KEY_LINES - 1; i >= 0; i--) begin
         if (row_any[i]) begin
            row = LINE_W'(i);
         end
         if (col_any[i]) begin
            col = LINE_W'(i);
         end
      end
   end

   assign found = |row_any;
   assign code  = key_ascii(3'(row), 3'(col));

endmodule

// ===== design/kps_engine.sv =====
// kps_engine: input register, press detection and bit timing state, result
// register; depends on kps_pkg and kps_key_decode
module kps_engine
   import kps_pkg::*;
#(
   parameter int KEY_LINES = KEY_LINES_DEF,
   parameter int CHAR_BITS = CHAR_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int BIT_W = $clog2(CHAR_BITS);

   logic    in_valid_ff;
   req_type in_word_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_word_ff, rsp_word_in;
   logic    advance;
   logic    fire;

   logic               was_pressed_ff, was_pressed_in;
   logic [COUNT_W-1:0] press_count_ff, press_count_in;
   logic [CODE_W-1:0]  last_key_ff, last_key_in;
   logic [CODE_W-1:0]  shift_ff, shift_in;
   logic [BIT_W-1:0]   bit_pos_ff, bit_pos_in;
   logic               high_phase_ff, high_phase_in;
   logic [TICK_W-1:0]  timer_ff, timer_in;
   logic               sending_ff, sending_in;

   logic               key_found;
   logic [CODE_W-1:0]  key_code;
   logic [TICK_W-1:0]  period;
   logic [TICK_W-1:0]  timer_inc;
   logic [BIT_W:0]     pos_inc;
   logic               taken, fresh, done;

   // the result register moves on when empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   kps_key_decode #(
      .KEY_LINES(KEY_LINES)
   ) u_decode (
      .key_mask(in_word_ff.key_mask),
      .found   (key_found),
      .code    (key_code)
   );

   assign period    = shift_ff[0] ? cfg.one_half_ticks : cfg.zero_half_ticks;
   assign timer_inc = timer_ff + TICK_W'(1);
   assign pos_inc   = {1'b0, bit_pos_ff} + (BIT_W+1)'(1);

   always_comb begin
      was_pressed_in = was_pressed_ff;
      press_count_in = press_count_ff;
      last_key_in    = last_key_ff;
      shift_in       = shift_ff;
      bit_pos_in     = bit_pos_ff;
      high_phase_in  = high_phase_ff;
      timer_in       = timer_ff;
      sending_in     = sending_ff;
      taken          = 1'b0;
      fresh          = 1'b0;
      done           = 1'b0;

      if (in_word_ff.cmd == CMD_SAMPLE) begin
         if (!sending_ff) begin
            taken = 1'b1;
            if (key_found && !was_pressed_ff) begin
               fresh          = 1'b1;
               press_count_in = (press_count_ff >= PRESS_LAST) ? '0
                                : press_count_ff + COUNT_W'(1);
               last_key_in    = key_code;
               shift_in       = key_code;
               bit_pos_in     = '0;
               high_phase_in  = 1'b0;
               timer_in       = '0;
               sending_in     = 1'b1;
            end
            was_pressed_in = key_found;
         end
      end else if (sending_ff) begin
         timer_in = timer_inc;
         // a zero period or a wrapped count also ends the phase
         if (timer_inc >= period || timer_inc == '0) begin
            timer_in = '0;
            if (!high_phase_ff) begin
               high_phase_in = 1'b1;
            end else begin
               high_phase_in = 1'b0;
               shift_in      = {1'b0, shift_ff[CODE_W-1:1]};
               bit_pos_in    = pos_inc[BIT_W-1:0];
               if (pos_inc >= (BIT_W+1)'(CHAR_BITS)) begin
                  bit_pos_in = '0;
                  sending_in = 1'b0;
                  done       = 1'b1;
               end
            end
         end
      end

      rsp_word_in.line_level   = sending_in && high_phase_in;
      rsp_word_in.busy_res     = sending_in;
      rsp_word_in.sample_taken = taken;
      rsp_word_in.new_press    = fresh;
      rsp_word_in.key_code     = last_key_in;
      rsp_word_in.press_count  = press_count_in;
      rsp_word_in.char_done    = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_pressed_ff <= 1'b0;
         press_count_ff <= '0;
         last_key_ff    <= '0;
         shift_ff       <= '0;
         bit_pos_ff     <= '0;
         high_phase_ff  <= 1'b0;
         timer_ff       <= '0;
         sending_ff     <= 1'b0;
      end else if (fire) begin
         was_pressed_ff <= was_pressed_in;
         press_count_ff <= press_count_in;
         last_key_ff    <= last_key_in;
         shift_ff       <= shift_in;
         bit_pos_ff     <= bit_pos_in;
         high_phase_ff  <= high_phase_in;
         timer_ff       <= timer_in;
         sending_ff     <= sending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== design/keypad_to_pulse_width_serial_top.sv =====
// keypad_to_pulse_width_serial_top: top level of the keypad scanner and
// pulse width serial sender; depends on kps_pkg, kps_csr, kps_engine
//
//   channel  ports                                 direction  handshake
//   req      req_valid req_stall req_word          in         valid / stall
//   rsp      rsp_valid rsp_stall rsp_word          out        valid / stall
//   csr      csr_valid csr_ready csr_index/wdata   in         valid / ready
//
// one word in per cycle while req_stall is low; a word's result is offered
// after the word passes the input register and then the result register;
// sustained rate is one word per clock while rsp_stall is low, set by the
// single state update step
// reset is synchronous, active high; clears engine state and both valids
// a stalled result holds in the result register; the input side stalls only
// when both registers are full
module keypad_to_pulse_width_serial_top
   import kps_pkg::*;
#(
   parameter int KEY_LINES = KEY_LINES_DEF,
   parameter int CHAR_BITS = CHAR_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]      csr_wdata
);

   cfg_type cfg;

   kps_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   kps_engine #(
      .KEY_LINES(KEY_LINES),
      .CHAR_BITS(CHAR_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

endmodule
